FILE: rtl/boa_pkg.sv
// Package with the types and constants shared by the byte occupancy allocator.
`timescale 1ns / 1ps

package boa_pkg;

  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = ADDR_W + 1;

  typedef enum logic [1:0] {
    CMD_CHECK   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_FIND    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_RANGE   = 2'd1,
    STS_OVERLAP = 2'd2,
    STS_NORUN   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/byte_occupancy_allocator.sv
// Top level of the byte occupancy allocator: bitmap, command sequencer and result register.
// Check scans the range; reserve scans the range and then writes it.
// Release writes the range without a scan; find scans the buffer from byte zero.
// Out-of-range and zero-length commands go straight to the result state.
// Every cycle handles one byte through the single-port occupancy memory, so one command
// runs at a time; busy stays high through its one-cycle result strobe, which cannot stall.
// Synchronous reset frees every byte at once through per-byte valid flags and clears the mark.
`timescale 1ns / 1ps

module byte_occupancy_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_start_offset,
  input  logic [8:0] in_range_length,
  input  logic [8:0] in_align_step,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_found_offset,
  output logic [7:0] out_conflict_index,
  output logic [8:0] out_used_end
);

  localparam int AW = boa_pkg::ADDR_W;
  localparam int CW = boa_pkg::CNT_W;
  localparam logic [CW:0]   BUF_SIZE = (CW+1)'(boa_pkg::BUF_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(boa_pkg::BUF_BYTES - 1);

  boa_pkg::state_t  state_r, state_nxt;
  boa_pkg::cmd_t    cmd_r, cmd_nxt;
  boa_pkg::status_t status_r, status_nxt;

  logic [AW-1:0] start_r, start_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] align_r, align_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic          in_run_r, in_run_nxt;
  logic [AW-1:0] cand_r, cand_nxt;
  logic [CW-1:0] ph_r, ph_nxt;
  logic [CW-1:0] hw_r, hw_nxt;
  logic [AW-1:0] found_r, found_nxt;
  logic [AW-1:0] conflict_r, conflict_nxt;

  logic                      occ_mem [boa_pkg::BUF_BYTES];
  logic [boa_pkg::BUF_BYTES-1:0] valid_r;
  logic                      rd_mem_r;
  logic                      rd_vld_r;
  logic                      occ_bit;
  logic                      wr_en;
  logic                      wr_data;

  logic [CW:0]   in_end;
  logic [CW:0]   cur_end;
  logic [CW-1:0] in_len;
  logic [AW-1:0] in_start;
  logic [CW-1:0] new_run;
  logic          run_ok;
  logic [AW-1:0] cand_new;
  logic [CW-1:0] ph_inc;

  assign in_len   = CW'(in_range_length);
  assign in_start = AW'(in_start_offset);
  assign in_end   = (CW+1)'(in_start) + (CW+1)'(in_len);
  assign cur_end  = (CW+1)'(start_r) + (CW+1)'(len_r);
  assign occ_bit  = rd_mem_r & rd_vld_r;
  assign new_run  = in_run_r ? run_r + CW'(1) : CW'(1);
  assign run_ok   = !occ_bit && (in_run_r || (ph_r == '0));
  assign cand_new = in_run_r ? cand_r : pidx_r;
  assign ph_inc   = ph_r + CW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      occ_mem[idx_r] <= wr_data;
    end
    rd_mem_r <= occ_mem[idx_r];
    rd_vld_r <= valid_r[idx_r];
    pidx_r   <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= boa_pkg::ST_IDLE;
      hw_r     <= '0;
      pend_r   <= 1'b0;
      in_run_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hw_r     <= hw_nxt;
      pend_r   <= pend_nxt;
      in_run_r <= in_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
    len_r      <= len_nxt;
    align_r    <= align_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    run_r      <= run_nxt;
    cand_r     <= cand_nxt;
    ph_r       <= ph_nxt;
    found_r    <= found_nxt;
    conflict_r <= conflict_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    status_nxt   = status_r;
    start_nxt    = start_r;
    len_nxt      = len_r;
    align_nxt    = align_r;
    idx_nxt      = idx_r;
    pend_nxt     = 1'b0;
    cnt_nxt      = cnt_r;
    run_nxt      = run_r;
    in_run_nxt   = in_run_r;
    cand_nxt     = cand_r;
    ph_nxt       = ph_r;
    hw_nxt       = hw_r;
    found_nxt    = found_r;
    conflict_nxt = conflict_r;
    wr_en        = 1'b0;
    wr_data      = (cmd_r == boa_pkg::CMD_RESERVE);

    unique case (state_r)
      boa_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt      = boa_pkg::cmd_t'(in_command);
          start_nxt    = in_start;
          len_nxt      = in_len;
          align_nxt    = (in_align_step == '0) ? CW'(1) : CW'(in_align_step);
          idx_nxt      = in_start;
          cnt_nxt      = in_len;
          status_nxt   = boa_pkg::STS_OK;
          found_nxt    = '0;
          conflict_nxt = '0;
          in_run_nxt   = 1'b0;
          run_nxt      = '0;
          cand_nxt     = '0;
          ph_nxt       = '0;
          if (in_command == boa_pkg::CMD_FIND) begin
            idx_nxt = '0;
            if (in_len == '0) begin
              state_nxt = boa_pkg::ST_DONE;
            end else if ((CW+1)'(in_len) > BUF_SIZE) begin
              status_nxt = boa_pkg::STS_NORUN;
              state_nxt  = boa_pkg::ST_DONE;
            end else begin
              state_nxt = boa_pkg::ST_FIND;
            end
          end else if (in_end > BUF_SIZE) begin
            status_nxt = boa_pkg::STS_RANGE;
            state_nxt  = boa_pkg::ST_DONE;
          end else if (in_len == '0) begin
            if (in_command == boa_pkg::CMD_RESERVE && CW'(in_start) > hw_r) begin
              hw_nxt = CW'(in_start);
            end
            state_nxt = boa_pkg::ST_DONE;
          end else if (in_command == boa_pkg::CMD_RELEASE) begin
            state_nxt = boa_pkg::ST_WRITE;
          end else begin
            state_nxt = boa_pkg::ST_SCAN;
          end
        end
      end
      boa_pkg::ST_SCAN: begin
        idx_nxt  = idx_r + AW'(1);
        pend_nxt = 1'b1;
        if (pend_r) begin
          if (occ_bit) begin
            status_nxt   = boa_pkg::STS_OVERLAP;
            conflict_nxt = pidx_r;
            pend_nxt     = 1'b0;
            state_nxt    = boa_pkg::ST_DONE;
          end else if (cnt_r == CW'(1)) begin
            pend_nxt = 1'b0;
            if (cmd_r == boa_pkg::CMD_RESERVE) begin
              idx_nxt   = start_r;
              cnt_nxt   = len_r;
              state_nxt = boa_pkg::ST_WRITE;
            end else begin
              state_nxt = boa_pkg::ST_DONE;
            end
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      boa_pkg::ST_FIND: begin
        idx_nxt  = idx_r + AW'(1);
        pend_nxt = 1'b1;
        if (pend_r) begin
          if (run_ok && new_run == len_r) begin
            status_nxt = boa_pkg::STS_OK;
            found_nxt  = cand_new;
            pend_nxt   = 1'b0;
            state_nxt  = boa_pkg::ST_DONE;
          end else if (pidx_r == LAST_IDX) begin
            status_nxt = boa_pkg::STS_NORUN;
            pend_nxt   = 1'b0;
            state_nxt  = boa_pkg::ST_DONE;
          end else begin
            in_run_nxt = run_ok;
            run_nxt    = new_run;
            cand_nxt   = cand_new;
            ph_nxt     = (ph_inc == align_r) ? '0 : ph_inc;
          end
        end
      end
      boa_pkg::ST_WRITE: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + AW'(1);
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = boa_pkg::ST_DONE;
          if (cmd_r == boa_pkg::CMD_RESERVE) begin
            if (cur_end > (CW+1)'(hw_r)) begin
              hw_nxt = CW'(cur_end);
            end
          end else if (cur_end == (CW+1)'(hw_r)) begin
            hw_nxt = CW'(start_r);
          end
        end
      end
      boa_pkg::ST_DONE: begin
        state_nxt = boa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = boa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != boa_pkg::ST_IDLE);
  assign out_valid          = (state_r == boa_pkg::ST_DONE);
  assign out_status         = status_r;
  assign out_found_offset   = 8'(found_r);
  assign out_conflict_index = 8'(conflict_r);
  assign out_used_end       = 9'(hw_r);

  // A transfer in starts a command, so the block reports busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Each command yields a single result strobe and then returns to idle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe lasted more than one cycle");

  // A conflict index is only reported alongside an overlap status.
  a_conflict_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != boa_pkg::STS_OVERLAP) |-> (out_conflict_index == '0))
    else $error("conflict index set without overlap");

  // A failed search leaves the found offset at zero.
  a_norun_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == boa_pkg::STS_NORUN) |-> (out_found_offset == '0))
    else $error("found offset set on failed search");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the byte occupancy allocator: queued driver, monitor and predictor.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    boa_pkg::cmd_t command;
    logic [7:0]    start_offset;
    logic [8:0]    range_length;
    logic [8:0]    align_step;
    int unsigned   gap_pct;
  } alloc_req_t;

  typedef struct {
    boa_pkg::status_t status;
    logic [7:0]       found_offset;
    logic [7:0]       conflict_index;
    logic [8:0]       used_end;
  } alloc_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_command = 2'd0;
  logic [7:0] in_start_offset = 8'd0;
  logic [8:0] in_range_length = 9'd0;
  logic [8:0] in_align_step = 9'd1;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_found_offset;
  logic [7:0] out_conflict_index;
  logic [8:0] out_used_end;

  alloc_req_t alloc_reqs[$];
  alloc_res_t expected_replies[$];
  alloc_req_t cur_req;
  logic       taken = 1'b0;
  int         errors = 0;

  logic [boa_pkg::BUF_BYTES-1:0] occ_map = '0;
  int                            hw_mark = 0;

  int held_start[$];
  int held_len[$];

  byte_occupancy_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_start_offset   (in_start_offset),
    .in_range_length   (in_range_length),
    .in_align_step     (in_align_step),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_offset  (out_found_offset),
    .out_conflict_index(out_conflict_index),
    .out_used_end      (out_used_end)
  );

  always #6 clk = ~clk;

  function automatic int first_used(int first, int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (first + k < boa_pkg::BUF_BYTES && occ_map[first + k]) return first + k;
    end
    return -1;
  endfunction

  task automatic predict_alloc(input alloc_req_t r, output alloc_res_t res);
    int len;
    int first;
    int range_end;
    int step;
    int pos;
    int hit;
    int k;
    res.status         = boa_pkg::STS_OK;
    res.found_offset   = 8'd0;
    res.conflict_index = 8'd0;
    len       = int'(r.range_length);
    first     = int'(r.start_offset);
    range_end = first + len;
    if (r.command == boa_pkg::CMD_FIND) begin
      step = (r.align_step == 9'd0) ? 1 : int'(r.align_step);
      res.status = boa_pkg::STS_NORUN;
      if (len <= boa_pkg::BUF_BYTES) begin
        for (pos = 0; pos + len <= boa_pkg::BUF_BYTES; pos += step) begin
          if (first_used(pos, len) < 0) begin
            res.status       = boa_pkg::STS_OK;
            res.found_offset = pos[7:0];
            break;
          end
        end
      end
    end else if (range_end > boa_pkg::BUF_BYTES) begin
      res.status = boa_pkg::STS_RANGE;
    end else if (r.command == boa_pkg::CMD_RELEASE) begin
      for (k = first; k < range_end; k++) occ_map[k] = 1'b0;
      if (range_end == hw_mark) hw_mark = first;
    end else begin
      hit = first_used(first, len);
      if (hit >= 0) begin
        res.status         = boa_pkg::STS_OVERLAP;
        res.conflict_index = hit[7:0];
      end else if (r.command == boa_pkg::CMD_RESERVE) begin
        for (k = first; k < range_end; k++) occ_map[k] = 1'b1;
        if (range_end > hw_mark) hw_mark = range_end;
      end
    end
    res.used_end = hw_mark[8:0];
  endtask

  task automatic add_req(boa_pkg::cmd_t cmd, int first, int len, int align, int unsigned gap);
    alloc_req_t r;
    r.command      = cmd;
    r.start_offset = first[7:0];
    r.range_length = len[8:0];
    r.align_step   = align[8:0];
    r.gap_pct      = gap;
    alloc_reqs.push_back(r);
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return $urandom_range(0, 3);
    if (sel < 75) return $urandom_range(4, 24);
    if (sel < 92) return $urandom_range(25, 128);
    return $urandom_range(129, 256);
  endfunction

  function automatic int pick_start(int len);
    int top;
    if ($urandom_range(9) < 2) return $urandom_range(0, 255);
    top = boa_pkg::BUF_BYTES - len;
    if (top > 255) top = 255;
    return $urandom_range(0, top);
  endfunction

  function automatic int pick_align();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 1;
    if (sel < 70) return 1 << $urandom_range(1, 8);
    if (sel < 75) return 0;
    return $urandom_range(0, 256);
  endfunction

  task automatic fill_random(int count);
    int i;
    int sel;
    int len;
    int first;
    int idx;
    int unsigned gap;
    for (i = 0; i < count; i++) begin
      gap = (i < 130) ? 0 : ((i < 270) ? 52 : 19);
      sel = $urandom_range(99);
      if (sel < 35) begin
        len   = pick_length();
        first = pick_start(len);
        add_req(boa_pkg::CMD_RESERVE, first, len, $urandom_range(0, 256), gap);
        if (first + len <= boa_pkg::BUF_BYTES) begin
          held_start.push_back(first);
          held_len.push_back(len);
        end
      end else if (sel < 38) begin
        add_req(boa_pkg::CMD_RELEASE, 0, boa_pkg::BUF_BYTES, $urandom_range(0, 256), gap);
        held_start.delete();
        held_len.delete();
      end else if (sel < 60) begin
        if (held_start.size() > 0 && $urandom_range(99) < 85) begin
          idx = $urandom_range(0, held_start.size() - 1);
          add_req(boa_pkg::CMD_RELEASE, held_start[idx], held_len[idx],
                  $urandom_range(0, 256), gap);
          held_start.delete(idx);
          held_len.delete(idx);
        end else begin
          len = pick_length();
          add_req(boa_pkg::CMD_RELEASE, pick_start(len), len, $urandom_range(0, 256), gap);
        end
      end else if (sel < 80) begin
        len = ($urandom_range(9) < 7) ? $urandom_range(0, 32) : $urandom_range(33, 256);
        add_req(boa_pkg::CMD_FIND, $urandom_range(0, 255), len, pick_align(), gap);
      end else begin
        len = pick_length();
        add_req(boa_pkg::CMD_CHECK, pick_start(len), len, $urandom_range(0, 256), gap);
      end
    end
  endtask

  // The driver holds a command until the transfer completes, then loads the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (alloc_reqs.size() > 0 && $urandom_range(99) >= alloc_reqs[0].gap_pct) begin
      cur_req         <= alloc_reqs[0];
      in_command      <= alloc_reqs[0].command;
      in_start_offset <= alloc_reqs[0].start_offset;
      in_range_length <= alloc_reqs[0].range_length;
      in_align_step   <= alloc_reqs[0].align_step;
      void'(alloc_reqs.pop_front());
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    alloc_res_t want;
    alloc_res_t got;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no outstanding command: status %0d", out_status);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_found_offset !== want.found_offset) begin
            $error("found_offset: expected %0d, actual %0d", want.found_offset,
                   out_found_offset);
            errors++;
          end
          if (out_conflict_index !== want.conflict_index) begin
            $error("conflict_index: expected %0d, actual %0d", want.conflict_index,
                   out_conflict_index);
            errors++;
          end
          if (out_used_end !== want.used_end) begin
            $error("used_end: expected %0d, actual %0d", want.used_end, out_used_end);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predict_alloc(cur_req, got);
        expected_replies.push_back(got);
      end
      taken <= start && !busy;
    end
  end

  initial begin
    add_req(boa_pkg::CMD_CHECK,     0,   0, 1, 0);
    add_req(boa_pkg::CMD_CHECK,   255,   1, 1, 0);
    add_req(boa_pkg::CMD_CHECK,     0, 256, 1, 0);
    add_req(boa_pkg::CMD_CHECK,     1, 256, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0, 256, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0, 257, 1, 0);
    add_req(boa_pkg::CMD_FIND,    255, 511, 0, 0);
    add_req(boa_pkg::CMD_FIND,      0,   0, 5, 0);
    add_req(boa_pkg::CMD_RESERVE,   0, 256, 1, 0);
    add_req(boa_pkg::CMD_CHECK,    10,   5, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0,   1, 1, 0);
    add_req(boa_pkg::CMD_RESERVE, 255,   1, 1, 0);
    add_req(boa_pkg::CMD_RELEASE,   0, 255, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0,   1, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0,   1, 256, 0);
    add_req(boa_pkg::CMD_RELEASE, 255,   1, 1, 0);
    add_req(boa_pkg::CMD_RELEASE, 100,   0, 1, 0);
    add_req(boa_pkg::CMD_RELEASE,   0, 255, 1, 0);
    add_req(boa_pkg::CMD_RESERVE, 200,   0, 1, 0);
    add_req(boa_pkg::CMD_RELEASE, 200,   0, 1, 0);
    add_req(boa_pkg::CMD_RELEASE, 255,   2, 1, 0);
    add_req(boa_pkg::CMD_RESERVE,  64,  64, 1, 0);
    add_req(boa_pkg::CMD_RESERVE,   0,  10, 1, 0);
    add_req(boa_pkg::CMD_FIND,      0,  64, 64, 0);
    add_req(boa_pkg::CMD_FIND,      0,  60, 3, 0);
    add_req(boa_pkg::CMD_RELEASE,   0, 256, 1, 0);
    fill_random(400);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (alloc_reqs.size() > 0 || start) @(posedge clk);
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule
